// File: src/slfe_pkg.sv
// shared types and constants of the serial link frame engine
// no dependencies; imported by serial_link_frame_engine_unit and its testbench
package slfe_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int FRAME_CAP   = (FRAME_BYTES < 256) ? FRAME_BYTES : 255;
    localparam int MAX_PAYLOAD = FRAME_CAP - 5;
    localparam int STORE_AW    = $clog2(FRAME_BYTES);

    // request codes carried in the low bits of s_tdata
    typedef enum logic [2:0] {
        MODE_LINE_RX = 3'd0,
        MODE_LINE_TX = 3'd1,
        MODE_PAYLOAD = 3'd2,
        MODE_TICK    = 3'd3,
        MODE_PULL    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ACK  = 2'd1,
        PH_PCK  = 2'd2,
        PH_KPA  = 2'd3
    } tx_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LENGTH   = 2'd1,
        ERR_DUP      = 2'd2,
        ERR_OVERLONG = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CFG_KEY_PACKET    = 3'd0,
        CFG_KEY_ACK       = 3'd1,
        CFG_KEY_KEEPALIVE = 3'd2,
        CFG_KA_TX_TICKS   = 3'd3,
        CFG_KA_RX_TICKS   = 3'd4
    } cfg_idx_t;

    localparam logic [7:0] ACK_FRAME_LEN = 8'd4;
    localparam logic [7:0] KPA_FRAME_LEN = 8'd3;
    localparam logic [7:0] FIRST_CODE_POS = 8'd3;

    typedef struct packed {
        logic       accepted;
        logic       line_valid;
        logic [7:0] line_out;
        logic       payload_valid;
        logic [7:0] payload_out;
        logic       payload_last;
        logic       clear_to_send;
        logic       link_open;
        err_t       error;
    } result_t;

endpackage

// File: src/slfe_ram.sv
// generic single-port-write, registered-read memory
// no dependencies
module slfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/serial_link_frame_engine_unit.sv
// Serial link frame engine: takes one request per clock while not stalled and
// returns one result per request; the received frame and the outgoing packet
// each sit in a 256 x 8 memory with registered read. The byte at the next
// decode or transmit pointer is fetched ahead, so a pull or a line byte
// request completes without waiting and requests may follow back to back; the
// result sits in an output register while the next request is accepted, and
// the input stalls only while that register holds a result not yet taken.
// Header bytes and the final code byte live in registers.
// Depends on slfe_pkg and slfe_ram.
module serial_link_frame_engine_unit
    import slfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[2:0], data_byte[10:3], zero fill
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // accepted, line_valid, line_out[9:2], payload_valid,
                                   // payload_out[18:11], clear_to_send, link_open,
                                   // error[22:21], zero fill
    output logic        m_tlast,   // payload_last
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [7:0]  key_pkt_reg, key_ack_reg, key_kpa_reg;
    logic [15:0] ka_tx_reg, ka_rx_reg;

    logic [8:0]  rx_count_reg, rx_count_next;
    logic        rx_held_reg, rx_held_next;
    logic [7:0]  rx_held_id_reg, rx_held_id_next;
    logic [7:0]  last_id_reg, last_id_next;
    logic [7:0]  dec_ptr_reg, dec_ptr_next;
    logic [7:0]  dec_run_reg, dec_run_next;
    logic [7:0]  rx_hdr_reg [4];
    logic [7:0]  rx_hdr_next [4];
    logic [8:0]  tx_len_reg, tx_len_next;
    logic        tx_sent_reg, tx_sent_next;
    logic [7:0]  tx_id_reg, tx_id_next;
    logic [7:0]  tx_key_reg, tx_key_next;
    logic [7:0]  fin_pos_reg, fin_pos_next;
    logic [7:0]  fin_code_reg, fin_code_next;
    logic [7:0]  enc_cnt_reg, enc_cnt_next;
    logic [7:0]  enc_pos_reg, enc_pos_next;
    tx_phase_t   phase_reg, phase_next;
    logic [7:0]  tx_ptr_reg, tx_ptr_next;
    logic        ack_pend_reg, ack_pend_next;
    logic [7:0]  ack_id_reg, ack_id_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] last_rx_reg, last_rx_next;
    logic [31:0] last_tx_reg, last_tx_next;
    logic        rx_seen_reg, rx_seen_next;

    logic        out_valid_reg;
    result_t     out_reg, res;

    logic        take;
    logic [2:0]  mode;
    logic [7:0]  din;

    logic                rx_we, tx_we;
    logic [STORE_AW-1:0] rx_waddr, tx_waddr;
    logic [7:0]          rx_wdata, tx_wdata, rx_rdata, tx_rdata;

    assign take     = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign mode     = s_tdata[2:0];
    assign din      = s_tdata[10:3];

    // prefetch the entry at the pointer the next request will see
    slfe_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (dec_ptr_next[STORE_AW-1:0]),
        .rdata (rx_rdata)
    );

    slfe_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (tx_ptr_next[STORE_AW-1:0]),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        logic [8:0]  wp9, end9, np9, total;
        logic [7:0]  h0, key, id, wp8, new_pos, n8, ptr_inc;
        logic [7:0]  code;
        logic [31:0] since;

        rx_count_next   = rx_count_reg;
        rx_held_next    = rx_held_reg;
        rx_held_id_next = rx_held_id_reg;
        last_id_next    = last_id_reg;
        dec_ptr_next    = dec_ptr_reg;
        dec_run_next    = dec_run_reg;
        for (int i = 0; i < 4; i++)
        begin
            rx_hdr_next[i] = rx_hdr_reg[i];
        end
        tx_len_next   = tx_len_reg;
        tx_sent_next  = tx_sent_reg;
        tx_id_next    = tx_id_reg;
        tx_key_next   = tx_key_reg;
        fin_pos_next  = fin_pos_reg;
        fin_code_next = fin_code_reg;
        enc_cnt_next  = enc_cnt_reg;
        enc_pos_next  = enc_pos_reg;
        phase_next    = phase_reg;
        tx_ptr_next   = tx_ptr_reg;
        ack_pend_next = ack_pend_reg;
        ack_id_next   = ack_id_reg;
        tick_next     = tick_reg;
        last_rx_next  = last_rx_reg;
        last_tx_next  = last_tx_reg;
        rx_seen_next  = rx_seen_reg;

        rx_we    = 1'b0;
        rx_waddr = rx_count_reg[STORE_AW-1:0];
        rx_wdata = din;
        tx_we    = 1'b0;
        tx_waddr = '0;
        tx_wdata = din;

        res = '0;

        wp9 = '0; end9 = '0; np9 = '0; total = '0;
        h0 = '0; key = '0; id = '0; wp8 = '0; new_pos = '0; n8 = '0;
        ptr_inc = '0; code = '0; since = '0;

        if (take)
        begin
            case (mode)
                MODE_LINE_RX:
                begin
                    if (!rx_held_reg)
                    begin
                        res.accepted = 1'b1;
                        if (rx_count_reg >= 9'(FRAME_BYTES))
                        begin
                            res.error     = ERR_OVERLONG;
                            rx_count_next = '0;
                        end
                        else
                        begin
                            rx_we = 1'b1;
                            if (rx_count_reg < 9'd4)
                            begin
                                rx_hdr_next[rx_count_reg[1:0]] = din;
                            end
                            rx_count_next = rx_count_reg + 9'd1;
                            if (din == 8'd0)
                            begin
                                wp9           = rx_count_reg + 9'd1;
                                rx_count_next = '0;
                                last_rx_next  = tick_reg;
                                rx_seen_next  = 1'b1;
                                h0  = (rx_count_reg == 9'd0) ? din : rx_hdr_reg[0];
                                key = rx_hdr_reg[1];
                                id  = (rx_count_reg == 9'd2) ? din : rx_hdr_reg[2];
                                end9 = wp9 - 9'd1;
                                if ({1'b0, h0} != wp9)
                                begin
                                    res.error = ERR_LENGTH;
                                end
                                else if (wp9 < 9'd3)
                                begin
                                    // too short to carry a key: dropped quietly
                                end
                                else if (key == key_pkt_reg)
                                begin
                                    if (id == last_id_reg)
                                    begin
                                        res.error = ERR_DUP;
                                    end
                                    else
                                    begin
                                        rx_held_next    = 1'b1;
                                        rx_held_id_next = id;
                                        last_id_next    = id;
                                        rx_count_next   = wp9;
                                        if (end9 <= 9'd3)
                                        begin
                                            dec_ptr_next = end9[7:0];
                                            dec_run_next = '0;
                                        end
                                        else
                                        begin
                                            dec_ptr_next = 8'd4;
                                            dec_run_next = (rx_hdr_reg[3] != 8'd0) ?
                                                           rx_hdr_reg[3] - 8'd1 : 8'd0;
                                        end
                                    end
                                end
                                else if (key == key_ack_reg)
                                begin
                                    if (id == tx_id_reg && phase_reg != PH_PCK)
                                    begin
                                        tx_len_next = '0;
                                    end
                                end
                            end
                        end
                    end
                end

                MODE_LINE_TX:
                begin
                    phase_next = phase_reg;
                    if (phase_reg == PH_IDLE)
                    begin
                        since = tick_reg - last_tx_reg;
                        priority if (ack_pend_reg)
                        begin
                            phase_next   = PH_ACK;
                            last_tx_next = tick_reg;
                        end
                        else if (tx_len_reg != 9'd0 && !tx_sent_reg)
                        begin
                            phase_next   = PH_PCK;
                            tx_sent_next = 1'b1;
                            last_tx_next = tick_reg;
                        end
                        else if (since > {16'd0, ka_tx_reg})
                        begin
                            phase_next   = PH_KPA;
                            last_tx_next = tick_reg;
                        end
                    end
                    // a frame starts at pointer zero: idle always leaves it there
                    if (phase_next != PH_IDLE)
                    begin
                        res.accepted   = 1'b1;
                        res.line_valid = 1'b1;
                        unique case (phase_next)
                            PH_ACK:
                            begin
                                total = 9'd4;
                                unique case (tx_ptr_reg)
                                    8'd0:    res.line_out = ACK_FRAME_LEN;
                                    8'd1:    res.line_out = key_ack_reg;
                                    8'd2:    res.line_out = ack_id_reg;
                                    default: res.line_out = 8'd0;
                                endcase
                            end
                            PH_PCK:
                            begin
                                total = tx_len_reg;
                                priority if (tx_ptr_reg == 8'd0)
                                    res.line_out = tx_len_reg[7:0];
                                else if (tx_ptr_reg == 8'd1)
                                    res.line_out = tx_key_reg;
                                else if (tx_ptr_reg == 8'd2)
                                    res.line_out = tx_id_reg;
                                else if (tx_ptr_reg == fin_pos_reg)
                                    res.line_out = fin_code_reg;
                                else if ({1'b0, tx_ptr_reg} == tx_len_reg - 9'd1)
                                    res.line_out = 8'd0;
                                else
                                    res.line_out = tx_rdata;
                            end
                            default:
                            begin
                                total = 9'd3;
                                unique case (tx_ptr_reg)
                                    8'd0:    res.line_out = KPA_FRAME_LEN;
                                    8'd1:    res.line_out = key_kpa_reg;
                                    default: res.line_out = 8'd0;
                                endcase
                            end
                        endcase
                        ptr_inc     = tx_ptr_reg + 8'd1;
                        tx_ptr_next = ptr_inc;
                        if ({1'b0, ptr_inc} >= total || ptr_inc == 8'd0)
                        begin
                            if (phase_next == PH_ACK)
                                ack_pend_next = 1'b0;
                            if (phase_next == PH_PCK)
                                tx_len_next = '0;
                            phase_next  = PH_IDLE;
                            tx_ptr_next = '0;
                        end
                    end
                end

                MODE_PAYLOAD:
                begin
                    if (tx_len_reg == 9'd0)
                    begin
                        res.accepted = 1'b1;
                        if (enc_cnt_reg >= 8'(MAX_PAYLOAD))
                        begin
                            res.error    = ERR_OVERLONG;
                            enc_cnt_next = '0;
                            enc_pos_next = FIRST_CODE_POS;
                        end
                        else
                        begin
                            wp8   = 8'd4 + enc_cnt_reg;
                            tx_we = 1'b1;
                            if (din == 8'd0)
                            begin
                                tx_waddr = enc_pos_reg[STORE_AW-1:0];
                                tx_wdata = wp8 - enc_pos_reg;
                                new_pos  = wp8;
                            end
                            else
                            begin
                                tx_waddr = wp8[STORE_AW-1:0];
                                tx_wdata = din;
                                new_pos  = enc_pos_reg;
                            end
                            enc_pos_next = new_pos;
                            enc_cnt_next = enc_cnt_reg + 8'd1;
                            if (s_tlast)
                            begin
                                // closing code byte is kept in a register
                                n8            = enc_cnt_reg + 8'd1;
                                fin_pos_next  = new_pos;
                                fin_code_next = 8'd4 + n8 - new_pos;
                                tx_id_next    = (tx_id_reg == 8'd255) ? 8'd1
                                                                      : tx_id_reg + 8'd1;
                                tx_key_next   = key_pkt_reg;
                                tx_len_next   = {1'b0, n8} + 9'd5;
                                tx_sent_next  = 1'b0;
                                enc_cnt_next  = '0;
                                enc_pos_next  = FIRST_CODE_POS;
                            end
                        end
                    end
                end

                MODE_TICK:
                begin
                    res.accepted = 1'b1;
                    tick_next    = tick_reg + 32'd1;
                end

                MODE_PULL:
                begin
                    if (rx_held_reg)
                    begin
                        end9 = rx_count_reg - 9'd1;
                        if ({1'b0, dec_ptr_reg} >= end9)
                        begin
                            if (!ack_pend_reg)
                            begin
                                res.accepted     = 1'b1;
                                res.payload_last = 1'b1;
                                rx_held_next     = 1'b0;
                                rx_count_next    = '0;
                                ack_pend_next    = 1'b1;
                                ack_id_next      = rx_held_id_reg;
                            end
                        end
                        else
                        begin
                            np9 = {1'b0, dec_ptr_reg} + 9'd1;
                            if (!(np9 >= end9 && ack_pend_reg))
                            begin
                                res.accepted      = 1'b1;
                                res.payload_valid = 1'b1;
                                dec_ptr_next      = np9[7:0];
                                if (dec_run_reg != 8'd0)
                                begin
                                    res.payload_out = rx_rdata;
                                    dec_run_next    = dec_run_reg - 8'd1;
                                end
                                else
                                begin
                                    code         = rx_rdata;
                                    dec_run_next = (code != 8'd0) ? code - 8'd1 : 8'd0;
                                end
                                if (np9 >= end9)
                                begin
                                    res.payload_last = 1'b1;
                                    rx_held_next     = 1'b0;
                                    rx_count_next    = '0;
                                    ack_pend_next    = 1'b1;
                                    ack_id_next      = rx_held_id_reg;
                                end
                            end
                        end
                    end
                end

                default:
                begin
                end
            endcase
        end

        res.clear_to_send = (tx_len_next == 9'd0);
        res.link_open     = rx_seen_next &&
                            ((tick_next - last_rx_next) < {16'd0, ka_rx_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pkt_reg <= 8'd1;
            key_ack_reg <= 8'd2;
            key_kpa_reg <= 8'd3;
            ka_tx_reg   <= 16'd800;
            ka_rx_reg   <= 16'd1200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_PACKET:    key_pkt_reg <= cfg_data[7:0];
                CFG_KEY_ACK:       key_ack_reg <= cfg_data[7:0];
                CFG_KEY_KEEPALIVE: key_kpa_reg <= cfg_data[7:0];
                CFG_KA_TX_TICKS:   ka_tx_reg   <= cfg_data;
                CFG_KA_RX_TICKS:   ka_rx_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg   <= '0;
            rx_held_reg    <= 1'b0;
            rx_held_id_reg <= '0;
            last_id_reg    <= '0;
            dec_ptr_reg    <= '0;
            dec_run_reg    <= '0;
            tx_len_reg     <= '0;
            tx_sent_reg    <= 1'b0;
            tx_id_reg      <= '0;
            enc_cnt_reg    <= '0;
            enc_pos_reg    <= FIRST_CODE_POS;
            phase_reg      <= PH_IDLE;
            tx_ptr_reg     <= '0;
            ack_pend_reg   <= 1'b0;
            ack_id_reg     <= '0;
            tick_reg       <= '0;
            last_rx_reg    <= '0;
            last_tx_reg    <= '0;
            rx_seen_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rx_count_reg   <= rx_count_next;
            rx_held_reg    <= rx_held_next;
            rx_held_id_reg <= rx_held_id_next;
            last_id_reg    <= last_id_next;
            dec_ptr_reg    <= dec_ptr_next;
            dec_run_reg    <= dec_run_next;
            tx_len_reg     <= tx_len_next;
            tx_sent_reg    <= tx_sent_next;
            tx_id_reg      <= tx_id_next;
            enc_cnt_reg    <= enc_cnt_next;
            enc_pos_reg    <= enc_pos_next;
            phase_reg      <= phase_next;
            tx_ptr_reg     <= tx_ptr_next;
            ack_pend_reg   <= ack_pend_next;
            ack_id_reg     <= ack_id_next;
            tick_reg       <= tick_next;
            last_rx_reg    <= last_rx_next;
            last_tx_reg    <= last_tx_next;
            rx_seen_reg    <= rx_seen_next;
            if (take)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // header, final code and output registers (no reset)
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            rx_hdr_reg[i] <= rx_hdr_next[i];
        end
        tx_key_reg   <= tx_key_next;
        fin_pos_reg  <= fin_pos_next;
        fin_code_reg <= fin_code_next;
        if (take)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.payload_last;
    assign m_tdata  = {1'b0, out_reg.error, out_reg.link_open, out_reg.clear_to_send,
                       out_reg.payload_out, out_reg.payload_valid, out_reg.line_out,
                       out_reg.line_valid, out_reg.accepted};

    // a held frame always has its length, key and id
    a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
        rx_held_reg |-> rx_count_reg >= 9'd3)
        else $error("held frame shorter than a header");

    a_pck_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PCK |-> tx_len_reg != 9'd0)
        else $error("packet transmit with no packet stored");

    a_enc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tx_len_reg != 9'd0 |-> enc_cnt_reg == 8'd0 && enc_pos_reg == FIRST_CODE_POS)
        else $error("encoder busy while a packet is outstanding");

endmodule

// File: tb/tb_serial_link_frame_engine_unit.sv
// testbench for serial_link_frame_engine_unit: stream requests in, results checked against
// an in-bench predictor of the frame engine; depends on slfe_pkg and the block's RTL
module tb_serial_link_frame_engine_unit;
    import slfe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 500;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    serial_link_frame_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // link model state
    logic [7:0]  lk_rxs [256];
    logic [7:0]  lk_txs [256];
    int          lk_rx_cnt, lk_dptr, lk_drun, lk_tx_len, lk_enc_cnt, lk_enc_pos, lk_tptr;
    bit          lk_held, lk_sent, lk_ackp, lk_seen;
    logic [7:0]  lk_held_id, lk_last_id, lk_tx_id, lk_ack_id;
    tx_phase_t   lk_ph;
    logic [31:0] lk_ticks, lk_last_rx, lk_last_tx;
    logic [7:0]  lk_k_pkt, lk_k_ack, lk_k_kpa;
    logic [15:0] lk_ka_tx, lk_ka_rx;

    result_t     expected_q [$];
    logic [7:0]  frame_q [$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          frames_held = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit          no_gaps = 0;
    int          hold_cycles = 0;
    int          rdy_style = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic link_reset();
        for (int i = 0; i < 256; i++)
        begin
            lk_rxs[i] = 8'd0;
            lk_txs[i] = 8'd0;
        end
        lk_rx_cnt = 0; lk_held = 0; lk_held_id = 0; lk_last_id = 0;
        lk_dptr = 0; lk_drun = 0; lk_tx_len = 0; lk_sent = 0; lk_tx_id = 0;
        lk_enc_cnt = 0; lk_enc_pos = 3; lk_ph = PH_IDLE; lk_tptr = 0;
        lk_ackp = 0; lk_ack_id = 0; lk_ticks = 0; lk_last_rx = 0; lk_last_tx = 0;
        lk_seen = 0;
        lk_k_pkt = 8'd1; lk_k_ack = 8'd2; lk_k_kpa = 8'd3;
        lk_ka_tx = 16'd800; lk_ka_rx = 16'd1200;
    endtask

    function automatic void tx_put(int i, int v);
        if (i < 256)
            lk_txs[i] = v[7:0];
    endfunction

    function automatic err_t rx_frame_done(int wp);
        logic [7:0] key;
        logic [7:0] id;
        logic [7:0] c;
        lk_last_rx = lk_ticks;
        lk_seen = 1;
        if (int'(lk_rxs[0]) != wp)
            return ERR_LENGTH;
        if (wp < 3)
            return ERR_NONE;
        key = lk_rxs[1];
        id = lk_rxs[2];
        if (key == lk_k_pkt)
        begin
            if (id == lk_last_id)
                return ERR_DUP;
            lk_held = 1; lk_held_id = id; lk_last_id = id; lk_rx_cnt = wp;
            if (wp - 1 <= 3)
            begin
                lk_dptr = wp - 1;
                lk_drun = 0;
            end
            else
            begin
                c = lk_rxs[3];
                lk_dptr = 4;
                lk_drun = (c != 0) ? int'(c) - 1 : 0;
            end
            return ERR_NONE;
        end
        if (key == lk_k_ack && id == lk_tx_id && lk_ph != PH_PCK)
            lk_tx_len = 0;
        return ERR_NONE;
    endfunction

    function automatic void release_packet();
        lk_held = 0; lk_rx_cnt = 0; lk_ackp = 1; lk_ack_id = lk_held_id;
    endfunction

    function automatic result_t link_step(logic [2:0] mode, logic [7:0] b, bit lastb);
        result_t r;
        int wp, np, nr, total, endp, n;
        logic [7:0] v, c;
        r = '0;
        r.error = ERR_NONE;
        case (mode)
            MODE_LINE_RX:
                if (!lk_held)
                begin
                    r.accepted = 1;
                    if (lk_rx_cnt >= FRAME_BYTES)
                    begin
                        r.error = ERR_OVERLONG;
                        lk_rx_cnt = 0;
                    end
                    else
                    begin
                        lk_rxs[lk_rx_cnt] = b;
                        lk_rx_cnt++;
                        if (b == 8'd0)
                        begin
                            wp = lk_rx_cnt;
                            lk_rx_cnt = 0;
                            r.error = rx_frame_done(wp);
                        end
                    end
                end
            MODE_LINE_TX:
            begin
                if (lk_ph == PH_IDLE)
                begin
                    if (lk_ackp)
                    begin
                        lk_ph = PH_ACK; lk_tptr = 0; lk_last_tx = lk_ticks;
                    end
                    else if (lk_tx_len != 0 && !lk_sent)
                    begin
                        lk_ph = PH_PCK; lk_tptr = 0; lk_sent = 1; lk_last_tx = lk_ticks;
                    end
                    else if ((lk_ticks - lk_last_tx) > {16'd0, lk_ka_tx})
                    begin
                        lk_ph = PH_KPA; lk_tptr = 0; lk_last_tx = lk_ticks;
                    end
                end
                if (lk_ph != PH_IDLE)
                begin
                    r.accepted = 1;
                    r.line_valid = 1;
                    if (lk_ph == PH_ACK)
                    begin
                        total = 4;
                        r.line_out = (lk_tptr == 0) ? ACK_FRAME_LEN : (lk_tptr == 1) ? lk_k_ack :
                                     (lk_tptr == 2) ? lk_ack_id : 8'd0;
                    end
                    else if (lk_ph == PH_PCK)
                    begin
                        total = lk_tx_len;
                        r.line_out = lk_txs[lk_tptr];
                    end
                    else
                    begin
                        total = 3;
                        r.line_out = (lk_tptr == 0) ? KPA_FRAME_LEN :
                                     (lk_tptr == 1) ? lk_k_kpa : 8'd0;
                    end
                    lk_tptr = (lk_tptr + 1) & 255;
                    if (lk_tptr >= total || lk_tptr == 0)
                    begin
                        if (lk_ph == PH_ACK)
                            lk_ackp = 0;
                        if (lk_ph == PH_PCK)
                            lk_tx_len = 0;
                        lk_ph = PH_IDLE;
                        lk_tptr = 0;
                    end
                end
            end
            MODE_PAYLOAD:
                if (lk_tx_len == 0)
                begin
                    r.accepted = 1;
                    if (lk_enc_cnt >= MAX_PAYLOAD)
                    begin
                        r.error = ERR_OVERLONG;
                        lk_enc_cnt = 0;
                        lk_enc_pos = 3;
                    end
                    else
                    begin
                        wp = 4 + lk_enc_cnt;
                        if (b == 8'd0)
                        begin
                            tx_put(lk_enc_pos, wp - lk_enc_pos);
                            lk_enc_pos = wp;
                        end
                        else
                            tx_put(wp, b);
                        lk_enc_cnt++;
                        if (lastb)
                        begin
                            n = lk_enc_cnt;
                            tx_put(lk_enc_pos, 4 + n - lk_enc_pos);
                            tx_put(4 + n, 0);
                            lk_tx_id = lk_tx_id + 8'd1;
                            if (lk_tx_id == 8'd0)
                                lk_tx_id = 8'd1;
                            tx_put(0, n + 5);
                            tx_put(1, lk_k_pkt);
                            tx_put(2, lk_tx_id);
                            lk_tx_len = n + 5;
                            lk_sent = 0;
                            lk_enc_cnt = 0;
                            lk_enc_pos = 3;
                        end
                    end
                end
            MODE_TICK:
            begin
                r.accepted = 1;
                lk_ticks = lk_ticks + 32'd1;
            end
            MODE_PULL:
                if (lk_held)
                begin
                    endp = lk_rx_cnt - 1;
                    if (lk_dptr >= endp)
                    begin
                        if (!lk_ackp)
                        begin
                            r.accepted = 1;
                            r.payload_last = 1;
                            release_packet();
                        end
                    end
                    else
                    begin
                        if (lk_drun > 0)
                        begin
                            v = lk_rxs[lk_dptr];
                            nr = lk_drun - 1;
                        end
                        else
                        begin
                            c = lk_rxs[lk_dptr];
                            v = 8'd0;
                            nr = (c != 0) ? int'(c) - 1 : 0;
                        end
                        np = lk_dptr + 1;
                        if (!(np >= endp && lk_ackp))
                        begin
                            r.accepted = 1;
                            r.payload_valid = 1;
                            r.payload_out = v;
                            lk_dptr = np & 255;
                            lk_drun = nr & 255;
                            if (np >= endp)
                            begin
                                r.payload_last = 1;
                                release_packet();
                            end
                        end
                    end
                end
            default: ;
        endcase
        r.clear_to_send = (lk_tx_len == 0);
        r.link_open = lk_seen && ((lk_ticks - lk_last_rx) < {16'd0, lk_ka_rx});
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, field, got, want);
        errors++;
    endtask

    // result checker: a transfer happens at the next rising edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[0] !== want.accepted)
                    report_mismatch("accepted", m_tdata[0], want.accepted);
                if (m_tdata[1] !== want.line_valid)
                    report_mismatch("line_valid", m_tdata[1], want.line_valid);
                if (m_tdata[9:2] !== want.line_out)
                    report_mismatch("line_out", m_tdata[9:2], want.line_out);
                if (m_tdata[10] !== want.payload_valid)
                    report_mismatch("payload_valid", m_tdata[10], want.payload_valid);
                if (m_tdata[18:11] !== want.payload_out)
                    report_mismatch("payload_out", m_tdata[18:11], want.payload_out);
                if (m_tlast !== want.payload_last)
                    report_mismatch("payload_last", m_tlast, want.payload_last);
                if (m_tdata[19] !== want.clear_to_send)
                    report_mismatch("clear_to_send", m_tdata[19], want.clear_to_send);
                if (m_tdata[20] !== want.link_open)
                    report_mismatch("link_open", m_tdata[20], want.link_open);
                if (m_tdata[22:21] !== want.error)
                    report_mismatch("error", m_tdata[22:21], want.error);
            end
            results_seen++;
        end
    end

    // receiver: ready follows one of three stall styles, long hold-off on demand
    always @(posedge clk)
    begin
        if (cycle_cnt % 64 == 0)
            rdy_style = $urandom_range(0, 2);
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (rdy_style == 0)
            m_tready <= 1'b1;
        else if (rdy_style == 1)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb_serial_link_frame_engine_unit: FAIL");
            $finish;
        end
    end

    // offer one request in bursts; returns the predicted result once it is taken
    task automatic send_req(logic [2:0] mode, logic [7:0] b, bit lastb, output result_t r);
        int gap;
        bit rdy;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, b, mode};
        s_tlast <= lastb;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        r = link_step(mode, b, lastb);
        expected_q.push_back(r);
        items_sent++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        go_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_KEY_PACKET:    lk_k_pkt = value[7:0];
            CFG_KEY_ACK:       lk_k_ack = value[7:0];
            CFG_KEY_KEEPALIVE: lk_k_kpa = value[7:0];
            CFG_KA_TX_TICKS:   lk_ka_tx = value;
            CFG_KA_RX_TICKS:   lk_ka_rx = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_keys(logic [7:0] kp, logic [7:0] ka, logic [7:0] kk);
        write_reg(CFG_KEY_PACKET, {8'd0, kp});
        write_reg(CFG_KEY_ACK, {8'd0, ka});
        write_reg(CFG_KEY_KEEPALIVE, {8'd0, kk});
    endtask

    // frame_q <= length, key, id, cobs(payload), delimiter
    task automatic build_frame(logic [7:0] key, logic [7:0] id, int n, int zero_odds);
        int code_at;
        logic [7:0] code;
        logic [7:0] b;
        frame_q.delete();
        frame_q.push_back(8'(n + 5));
        frame_q.push_back(key);
        frame_q.push_back(id);
        code_at = frame_q.size();
        frame_q.push_back(8'd0);
        code = 8'd1;
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 99) < zero_odds) ? 8'd0 : 8'($urandom_range(1, 255));
            if (b == 8'd0)
            begin
                frame_q[code_at] = code;
                code_at = frame_q.size();
                frame_q.push_back(8'd0);
                code = 8'd1;
            end
            else
            begin
                frame_q.push_back(b);
                code++;
            end
        end
        frame_q[code_at] = code;
        frame_q.push_back(8'd0);
    endtask

    task automatic drain_rx();
        result_t r;
        while (lk_held)
        begin
            send_req(MODE_PULL, 8'($urandom), $urandom_range(0, 1), r);
            if (!r.accepted)
                send_req(MODE_LINE_TX, 8'($urandom), $urandom_range(0, 1), r);
        end
    endtask

    task automatic send_frame_q();
        result_t r;
        drain_rx();
        foreach (frame_q[i])
            send_req(MODE_LINE_RX, frame_q[i], $urandom_range(0, 1), r);
        if (lk_held)
            frames_held++;
    endtask

    task automatic drain_tx();
        result_t r;
        do
            send_req(MODE_LINE_TX, 8'($urandom), $urandom_range(0, 1), r);
        while (r.accepted);
    endtask

    task automatic send_payload(int n, int zero_odds);
        result_t r;
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 99) < zero_odds) ? 8'd0 : 8'($urandom);
            send_req(MODE_PAYLOAD, b, i == n - 1, r);
        end
    endtask

    task automatic send_ticks(int n);
        result_t r;
        repeat (n) send_req(MODE_TICK, 8'($urandom), $urandom_range(0, 1), r);
    endtask

    task automatic test_idle_requests();
        result_t r;
        send_req(MODE_LINE_TX, 8'hff, 1'b1, r);
        send_req(MODE_PULL, 8'h00, 1'b0, r);
        send_req(3'd5, 8'haa, 1'b1, r);
        send_req(3'd6, 8'h55, 1'b0, r);
        send_req(3'd7, 8'hff, 1'b1, r);
        send_ticks(2);
    endtask

    task automatic test_rx_packets();
        result_t r;
        build_frame(lk_k_pkt, 8'd5, 6, 30);
        send_frame_q();
        // line byte refused while a packet is held
        send_req(MODE_LINE_RX, 8'h00, 1'b0, r);
        drain_rx();
        // repeat of the same id is refused
        build_frame(lk_k_pkt, 8'd5, 2, 0);
        send_frame_q();
        // second packet while the ack is still queued: final pull waits
        build_frame(lk_k_pkt, 8'd6, 3, 50);
        send_frame_q();
        drain_rx();
        drain_tx();
        // empty packet
        frame_q = '{8'd4, lk_k_pkt, 8'd7, 8'd0};
        send_frame_q();
        drain_rx();
        // code 255 and a group running past the frame end
        frame_q = '{8'd7, lk_k_pkt, 8'd8, 8'd255, 8'd9, 8'd20, 8'd0};
        send_frame_q();
        drain_rx();
        drain_tx();
    endtask

    task automatic test_bad_frames();
        result_t r;
        frame_q = '{8'd9, lk_k_pkt, 8'd11, 8'd0};
        send_frame_q();
        frame_q = '{8'd0};
        send_frame_q();
        frame_q = '{8'd2, 8'd0};
        send_frame_q();
        frame_q = '{8'd4, 8'd77, 8'd1, 8'd0};
        send_frame_q();
        // overlong frame: one byte past a full store
        for (int i = 0; i < FRAME_BYTES + 1; i++)
            send_req(MODE_LINE_RX, 8'($urandom_range(1, 255)), 1'b0, r);
    endtask

    task automatic test_tx_packets();
        result_t r;
        send_payload(5, 40);
        // payload refused while a packet is outstanding
        send_req(MODE_PAYLOAD, 8'h12, 1'b1, r);
        send_req(MODE_LINE_TX, 8'd0, 1'b0, r);
        // ack in the middle of transmission is ignored
        frame_q = '{8'd4, lk_k_ack, lk_tx_id, 8'd0};
        send_frame_q();
        drain_tx();
        send_payload(1, 0);
        drain_tx();
        frame_q = '{8'd4, lk_k_ack, lk_tx_id, 8'd0};
        send_frame_q();
        // longest payload, then payload bytes refused while it is outstanding
        send_payload(MAX_PAYLOAD, 10);
        send_req(MODE_PAYLOAD, 8'h01, 1'b0, r);
        send_req(MODE_PAYLOAD, 8'h80, 1'b1, r);
        drain_tx();
    endtask

    task automatic test_keepalive();
        write_reg(CFG_KA_TX_TICKS, 16'd1);
        write_reg(CFG_KA_RX_TICKS, 16'd1);
        send_ticks(3);
        drain_tx();
        frame_q = '{8'd2, 8'd0};
        send_frame_q();
        send_ticks(2);
        write_reg(CFG_KA_TX_TICKS, 16'hffff);
        write_reg(CFG_KA_RX_TICKS, 16'hffff);
        send_ticks(3);
        drain_tx();
    endtask

    task automatic test_key_settings();
        // equal keys: packet wins
        set_keys(8'hff, 8'hff, 8'hff);
        build_frame(8'hff, 8'd40, 2, 0);
        send_frame_q();
        drain_rx();
        drain_tx();
        // key zero ends a frame at the key byte
        set_keys(8'd0, 8'd0, 8'd0);
        frame_q = '{8'd2, 8'd0, 8'd41, 8'd0};
        send_frame_q();
        set_keys(8'd1, 8'd2, 8'd3);
    endtask

    task automatic test_backpressure();
        go_idle();
        hold_cycles = 400;
        no_gaps = 1;
        send_ticks(60);
        no_gaps = 0;
    endtask

    task automatic random_item();
        int pick;
        int n;
        result_t r;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (pick < 40)
        begin
            if ($urandom_range(0, 4) == 0)
                build_frame(lk_k_ack, ($urandom_range(0, 1) != 0) ? lk_tx_id : 8'($urandom),
                            0, 0);
            else if ($urandom_range(0, 9) == 0)
                build_frame(($urandom_range(0, 1) != 0) ? lk_k_kpa : 8'($urandom_range(1, 255)),
                            8'($urandom), n, 25);
            else
                build_frame(lk_k_pkt, ($urandom_range(0, 7) == 0) ? lk_last_id : 8'($urandom),
                            n, 25);
            if ($urandom_range(0, 9) == 0)
                frame_q[$urandom_range(0, frame_q.size() - 2)] = 8'($urandom);
            send_frame_q();
        end
        else if (pick < 58)
        begin
            if (lk_tx_len == 0)
                send_payload(n + 1, 20);
            else
                send_req(MODE_PAYLOAD, 8'($urandom), $urandom_range(0, 1), r);
        end
        else if (pick < 78)
            repeat ($urandom_range(1, 8))
                send_req(MODE_LINE_TX, 8'($urandom), $urandom_range(0, 1), r);
        else if (pick < 88)
            send_ticks($urandom_range(1, 12));
        else if (pick < 97)
            repeat ($urandom_range(1, 6))
                send_req(MODE_PULL, 8'($urandom), $urandom_range(0, 1), r);
        else
            send_req(3'($urandom_range(5, 7)), 8'($urandom), $urandom_range(0, 1), r);
    endtask

    task automatic test_random();
        int target;
        target = items_sent + RANDOM_ITEMS;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_KA_TX_TICKS, 16'd5);  write_reg(CFG_KA_RX_TICKS, 16'd20); end
                1: begin write_reg(CFG_KA_TX_TICKS, 16'd1);  write_reg(CFG_KA_RX_TICKS, 16'd1);  end
                2: begin write_reg(CFG_KA_TX_TICKS, 16'd30); write_reg(CFG_KA_RX_TICKS, 16'hffff); end
                default: set_keys(8'hfe, 8'h80, 8'h7f);
            endcase
            while (items_sent < target - (3 - ph) * RANDOM_ITEMS / 4)
                random_item();
        end
    endtask

    initial
    begin
        int waited;
        link_reset();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_PACKET;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_requests();
        test_rx_packets();
        test_bad_frames();
        test_tx_packets();
        test_keepalive();
        test_key_settings();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results never arrived", expected_q.size(), 0);
        $display("covered %0d requests, %0d results, %0d packets held, in %0d cycles",
                 items_sent, results_seen, frames_held, cycle_cnt);
        if (errors == 0)
            $display("tb_serial_link_frame_engine_unit: PASS");
        else
            $display("tb_serial_link_frame_engine_unit: FAIL");
        $finish;
    end

endmodule
